[hw/rtl/ece_pkg.sv]
// Shared types, constants and register codes for the easing curve evaluator.
`default_nettype none

package ece_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned MODE_W        = 3;
    localparam int unsigned CFG_IDX_W     = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_HOLD        = 3'd0,
        MODE_LINEAR      = 3'd1,
        MODE_EASE_IN     = 3'd2,
        MODE_EASE_OUT    = 3'd3,
        MODE_EASE_IN_OUT = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURVE_MODE = 1'd0,
        CFG_DURATION   = 1'd1
    } t_cfg_reg;

    typedef struct packed {
        t_mode              curve_mode;
        logic [DATA_W-1:0]  duration;
    } t_cfg;

    // Per-item operands that ride alongside the quotient.
    typedef struct packed {
        logic signed [DATA_W-1:0] start_value;
        logic signed [DATA_W-1:0] change_value;
        logic                     first_half;
    } t_side;

    typedef struct packed {
        logic signed [DATA_W-1:0] eased_value;
        logic                     saturated;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/ece_ifs.sv]
// Valid/ready channel interfaces: configuration writes, input items, results.
`default_nettype none

interface ece_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [ece_pkg::CFG_IDX_W-1:0]          reg_index;
    logic [ece_pkg::DATA_W-1:0]             wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

interface ece_item_if;
    logic                                   valid;
    logic                                   ready;
    logic        [ece_pkg::DATA_W-1:0]      elapsed_time;
    logic signed [ece_pkg::DATA_W-1:0]      start_value;
    logic signed [ece_pkg::DATA_W-1:0]      change_value;

    modport source (output valid, output elapsed_time, output start_value,
                    output change_value, input ready);
    modport sink   (input valid, input elapsed_time, input start_value,
                    input change_value, output ready);
endinterface

interface ece_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ece_pkg::DATA_W-1:0]      eased_value;
    logic                                   saturated;

    modport source (output valid, output eased_value, output saturated, input ready);
    modport sink   (input valid, input eased_value, input saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/easing_curve_evaluator.sv]
// Top level: configuration registers, compute pipeline and output skid buffer.
//
//  Channel   Dir   Handshake      Payload
//  i_cfg     in    valid/ready    reg_index (0 curve_mode, 1 duration), wdata
//  i_item    in    valid/ready    elapsed_time, start_value, change_value
//  o_result  out   valid/ready    eased_value, saturated
//
// One item per cycle while the skid register is empty; the path runs through the
// divider's input register and FRAC_BITS + 32 one-bit steps, four curve stages,
// three scale stages and the output register.
// Synchronous active-low reset clears valid bits, curve_mode and duration.
// The whole pipeline holds while the skid register is full; i_item.ready is the
// inverse of that flag, so input is taken while a result waits at the output.
// i_cfg is always ready; write it only while the pipeline is empty.
`default_nettype none

module easing_curve_evaluator #(
    parameter int unsigned FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ece_cfg_if.sink          i_cfg,
    ece_item_if.sink         i_item,
    ece_result_if.source     o_result
);

    localparam int unsigned DW = ece_pkg::DATA_W;
    localparam int unsigned QW = DW + FRAC_BITS;
    localparam int unsigned KW = 2 * FRAC_BITS + 37;

    ece_pkg::t_mode       r_mode;
    logic [DW-1:0]        r_duration;
    ece_pkg::t_cfg        cfg;

    logic                 en;
    ece_pkg::t_side       in_side;
    logic                 div_v;
    logic [QW-1:0]        div_q;
    ece_pkg::t_side       div_side;
    logic                 crv_v;
    logic signed [KW-1:0] crv_k;
    ece_pkg::t_side       crv_side;
    logic                 pipe_v;
    ece_pkg::t_result     pipe_res;

    logic                 r_out_v;
    logic                 r_skid_v;
    ece_pkg::t_result     r_out_data;
    ece_pkg::t_result     r_skid_data;
    logic                 n_out_v;
    logic                 n_skid_v;
    logic                 load_out_pipe;
    logic                 load_out_skid;
    logic                 load_skid;
    logic                 take;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ece_pkg::MODE_HOLD;
            r_duration <= '0;
        end else if (i_cfg.valid) begin
            unique case (ece_pkg::t_cfg_reg'(i_cfg.reg_index))
                ece_pkg::CFG_CURVE_MODE: r_mode <= ece_pkg::t_mode'(i_cfg.wdata[ece_pkg::MODE_W-1:0]);
                ece_pkg::CFG_DURATION:   r_duration <= i_cfg.wdata;
                default:                 r_duration <= r_duration;
            endcase
        end
    end

    assign cfg.curve_mode = r_mode;
    assign cfg.duration   = r_duration;

    // input side
    assign en           = ~r_skid_v;
    assign i_item.ready = en;

    always_comb begin
        in_side.start_value  = i_item.start_value;
        in_side.change_value = i_item.change_value;
        in_side.first_half   = ({i_item.elapsed_time, 1'b0} < {1'b0, r_duration});
    end

    ece_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_item.valid),
        .i_time     (i_item.elapsed_time),
        .i_divisor  (r_duration),
        .i_side     (in_side),
        .o_valid    (div_v),
        .o_quotient (div_q),
        .o_side     (div_side)
    );

    ece_curve #(.FRAC_BITS(FRAC_BITS)) u_curve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_mode     (r_mode),
        .i_valid    (div_v),
        .i_quotient (div_q),
        .i_side     (div_side),
        .o_valid    (crv_v),
        .o_k        (crv_k),
        .o_side     (crv_side)
    );

    ece_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_cfg      (cfg),
        .i_valid    (crv_v),
        .i_k        (crv_k),
        .i_side     (crv_side),
        .o_valid    (pipe_v),
        .o_result   (pipe_res)
    );

    // output skid buffer
    always_comb begin
        take          = r_out_v & o_result.ready;
        n_out_v       = r_out_v;
        n_skid_v      = r_skid_v;
        load_out_pipe = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (r_skid_v) begin
            if (take) begin
                load_out_skid = 1'b1;
                n_skid_v      = 1'b0;
            end
        end else if (pipe_v) begin
            if (r_out_v && !o_result.ready) begin
                load_skid = 1'b1;
                n_skid_v  = 1'b1;
            end else begin
                load_out_pipe = 1'b1;
                n_out_v       = 1'b1;
            end
        end else if (take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_pipe) begin
            r_out_data <= pipe_res;
        end else if (load_out_skid) begin
            r_out_data <= r_skid_data;
        end
        if (load_skid) begin
            r_skid_data <= pipe_res;
        end
    end

    assign o_result.valid       = r_out_v;
    assign o_result.eased_value = r_out_data.eased_value;
    assign o_result.saturated   = r_out_data.saturated;

endmodule

`default_nettype wire

[hw/rtl/ece_divider.sv]
// Pipelined restoring divider: normalized time = (elapsed << FRAC_BITS) / duration.
`default_nettype none

module ece_divider #(
    parameter int unsigned FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [ece_pkg::DATA_W-1:0]     i_time,
    input  wire logic [ece_pkg::DATA_W-1:0]     i_divisor,
    input  wire ece_pkg::t_side                 i_side,
    output logic                                o_valid,
    output logic [ece_pkg::DATA_W+FRAC_BITS-1:0] o_quotient,
    output ece_pkg::t_side                      o_side
);

    localparam int unsigned DW = ece_pkg::DATA_W;
    localparam int unsigned QW = DW + FRAC_BITS;

    logic                 r_v    [0:QW];
    logic [DW-1:0]        r_rem  [0:QW];
    // Upper bits hold dividend bits still to use, lower bits the quotient so far.
    logic [QW-1:0]        r_nq   [0:QW];
    ece_pkg::t_side       r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_nq[0]   <= {i_time, {FRAC_BITS{1'b0}}};
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_nq;

        always_comb begin
            trial = {r_rem[s-1], r_nq[s-1][QW-1]};
            diff  = {1'b0, trial} - {2'b00, i_divisor};
            ge    = ~diff[DW+1];
            n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_nq  = {r_nq[s-1][QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_nq[s]   <= n_nq;
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid    = r_v[QW];
    assign o_quotient = r_nq[QW];
    assign o_side     = r_side[QW];

endmodule

`default_nettype wire

[hw/rtl/ece_curve.sv]
// Curve shaping: clamp normalized time, square it in parts, form the curve factor.
`default_nettype none

module ece_curve #(
    parameter int unsigned FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire ece_pkg::t_mode                      i_mode,
    input  wire logic                                i_valid,
    input  wire logic [ece_pkg::DATA_W+FRAC_BITS-1:0] i_quotient,
    input  wire ece_pkg::t_side                      i_side,
    output logic                                     o_valid,
    output logic signed [2*FRAC_BITS+36:0]           o_k,
    output ece_pkg::t_side                           o_side
);

    localparam int unsigned QW  = ece_pkg::DATA_W + FRAC_BITS;
    localparam int unsigned UW  = FRAC_BITS + 18;
    localparam int unsigned HW  = (UW + 1) / 2;
    localparam int unsigned TW  = UW - HW;
    localparam int unsigned SQW = 2 * UW;
    localparam int unsigned KW  = 2 * FRAC_BITS + 37;
    localparam logic [QW-1:0]         CAP_U   = QW'(1) << (FRAC_BITS + 17);
    localparam logic signed [KW-1:0]  ONE_SQ  = KW'(1) << (2 * FRAC_BITS);

    // stage A: clamp
    logic                 r_a_v;
    logic [QW-1:0]        r_a_u;
    logic [UW-1:0]        r_a_uc;
    ece_pkg::t_side       r_a_side;
    // stage B: partial squares
    logic                 r_b_v;
    logic [QW-1:0]        r_b_u;
    logic [UW-1:0]        r_b_uc;
    logic [2*HW-1:0]      r_b_pll;
    logic [UW-1:0]        r_b_plh;
    logic [2*TW-1:0]      r_b_phh;
    ece_pkg::t_side       r_b_side;
    // stage C: square
    logic                 r_c_v;
    logic [QW-1:0]        r_c_u;
    logic [UW-1:0]        r_c_uc;
    logic [SQW-1:0]       r_c_sq;
    ece_pkg::t_side       r_c_side;
    // stage D: curve factor
    logic                 r_d_v;
    logic signed [KW-1:0] r_d_k;
    ece_pkg::t_side       r_d_side;

    logic [UW-1:0]        n_uc;
    logic [HW-1:0]        ul;
    logic [TW-1:0]        uh;
    logic [SQW-1:0]       n_sq;
    logic signed [KW-1:0] sq_s;
    logic signed [KW-1:0] u_s;
    logic signed [KW-1:0] uc_s;
    logic signed [KW-1:0] n_k;

    always_comb begin
        n_uc = (i_quotient > CAP_U) ? CAP_U[UW-1:0] : i_quotient[UW-1:0];
        ul   = r_a_uc[HW-1:0];
        uh   = r_a_uc[UW-1:HW];
        n_sq = (SQW'(r_b_phh) << (2 * HW)) + (SQW'(r_b_plh) << (HW + 1)) + SQW'(r_b_pll);
    end

    always_comb begin
        sq_s = $signed(KW'(r_c_sq));
        u_s  = $signed(KW'(r_c_u));
        uc_s = $signed(KW'(r_c_uc));
        case (i_mode)
            ece_pkg::MODE_LINEAR:   n_k = u_s <<< FRAC_BITS;
            ece_pkg::MODE_EASE_IN:  n_k = sq_s;
            ece_pkg::MODE_EASE_OUT: n_k = (uc_s <<< (FRAC_BITS + 1)) - sq_s;
            ece_pkg::MODE_EASE_IN_OUT: begin
                if (r_c_side.first_half) begin
                    n_k = sq_s <<< 1;
                end else begin
                    n_k = (uc_s <<< (FRAC_BITS + 2)) - (sq_s <<< 1) - ONE_SQ;
                end
            end
            default:                n_k = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_u    <= i_quotient;
            r_a_uc   <= n_uc;
            r_a_side <= i_side;

            r_b_u    <= r_a_u;
            r_b_uc   <= r_a_uc;
            r_b_pll  <= (2*HW)'(ul) * (2*HW)'(ul);
            r_b_plh  <= UW'(uh) * UW'(ul);
            r_b_phh  <= (2*TW)'(uh) * (2*TW)'(uh);
            r_b_side <= r_a_side;

            r_c_u    <= r_b_u;
            r_c_uc   <= r_b_uc;
            r_c_sq   <= n_sq;
            r_c_side <= r_b_side;

            r_d_k    <= n_k;
            r_d_side <= r_c_side;
        end
    end

    assign o_valid = r_d_v;
    assign o_k     = r_d_k;
    assign o_side  = r_d_side;

endmodule

`default_nettype wire

[hw/rtl/ece_scale.sv]
// Scale the curve factor by the change value, rescale, add start value, saturate.
`default_nettype none

module ece_scale #(
    parameter int unsigned FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire ece_pkg::t_cfg               i_cfg,
    input  wire logic                        i_valid,
    input  wire logic signed [2*FRAC_BITS+36:0] i_k,
    input  wire ece_pkg::t_side              i_side,
    output logic                             o_valid,
    output ece_pkg::t_result                 o_result
);

    localparam int unsigned DW  = ece_pkg::DATA_W;
    localparam int unsigned KW  = 2 * FRAC_BITS + 37;
    localparam int unsigned L   = (KW + 2) / 3;
    localparam int unsigned K2W = KW - 2 * L;
    localparam int unsigned PW  = KW + DW;
    localparam int unsigned SW  = PW - 2 * FRAC_BITS;
    localparam logic [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic ece_pkg::t_result f_clip(input logic signed [SW-1:0] v);
        ece_pkg::t_result r;
        logic [SW-DW:0]   top;
        top = v[SW-1:DW-1];
        if ((top == '0) || (top == '1)) begin
            r.eased_value = $signed(v[DW-1:0]);
            r.saturated   = 1'b0;
        end else begin
            r.eased_value = $signed(v[SW-1] ? S32_MIN : S32_MAX);
            r.saturated   = 1'b1;
        end
        return r;
    endfunction

    // stage E: partial products
    logic                    r_e_v;
    logic signed [L+DW:0]    r_e_p0;
    logic signed [L+DW:0]    r_e_p1;
    logic signed [K2W+DW-1:0] r_e_p2;
    ece_pkg::t_side          r_e_side;
    // stage F: full product
    logic                    r_f_v;
    logic signed [PW-1:0]    r_f_prod;
    ece_pkg::t_side          r_f_side;
    // stage G: result
    logic                    r_g_v;
    ece_pkg::t_result        r_g_res;

    logic signed [L+DW:0]     n_p0;
    logic signed [L+DW:0]     n_p1;
    logic signed [K2W+DW-1:0] n_p2;
    logic signed [PW-1:0]     e0;
    logic signed [PW-1:0]     e1;
    logic signed [PW-1:0]     e2;
    logic signed [PW-1:0]     n_prod;
    logic signed [PW-1:0]     shifted;
    logic signed [SW-1:0]     b_ext;
    logic signed [SW-1:0]     c_ext;
    logic signed [SW-1:0]     curve_sum;
    logic signed [SW-1:0]     direct_sum;
    ece_pkg::t_result         n_res;

    always_comb begin
        n_p0 = $signed({1'b0, i_k[L-1:0]}) * i_side.change_value;
        n_p1 = $signed({1'b0, i_k[2*L-1:L]}) * i_side.change_value;
        n_p2 = $signed(i_k[KW-1:2*L]) * i_side.change_value;

        e0     = r_e_p0;
        e1     = r_e_p1;
        e2     = r_e_p2;
        n_prod = (e2 <<< (2 * L)) + (e1 <<< L) + e0;
    end

    always_comb begin
        shifted    = r_f_prod >>> (2 * FRAC_BITS);
        b_ext      = r_f_side.start_value;
        c_ext      = r_f_side.change_value;
        curve_sum  = $signed(shifted[SW-1:0]) + b_ext;
        direct_sum = b_ext + c_ext;
        n_res      = '0;
        case (i_cfg.curve_mode) inside
            ece_pkg::MODE_HOLD: begin
                n_res.eased_value = r_f_side.start_value;
            end
            ece_pkg::MODE_LINEAR, ece_pkg::MODE_EASE_IN, ece_pkg::MODE_EASE_OUT,
            ece_pkg::MODE_EASE_IN_OUT: begin
                n_res = (i_cfg.duration == '0) ? f_clip(direct_sum) : f_clip(curve_sum);
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= i_valid;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_p0   <= n_p0;
            r_e_p1   <= n_p1;
            r_e_p2   <= n_p2;
            r_e_side <= i_side;
            r_f_prod <= n_prod;
            r_f_side <= r_e_side;
            r_g_res  <= n_res;
        end
    end

    assign o_valid  = r_g_v;
    assign o_result = r_g_res;

endmodule

`default_nettype wire
